// ===== sv/qnlerp_pkg.sv =====
// shared widths, constants and beat types for the quaternion nlerp pipeline
// no dependencies
`default_nettype none

package qnlerp_pkg;

	localparam int COMP_WIDTH  = 16;
	localparam int FRAC_BITS   = COMP_WIDTH - 2;
	localparam int BLEND_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	// product of a component and a 17-bit blend weight
	localparam int PROD_WIDTH  = COMP_WIDTH + BLEND_WIDTH + 1;
	localparam int SQ_WIDTH    = 2 * COMP_WIDTH;
	localparam int SUM_WIDTH   = 2 * COMP_WIDTH + 2;
	localparam int ACC_WIDTH   = 4 * COMP_WIDTH + 4;
	localparam int QUO_WIDTH   = FRAC_BITS + 1;
	localparam int NORM_LAT    = FRAC_BITS + 2;

	localparam logic [BLEND_WIDTH:0] BLEND_ONE = (BLEND_WIDTH + 1)'(1) << (BLEND_WIDTH - 1);
	localparam logic [CFG_WIDTH-1:0] MIN_LENGTH_RST = CFG_WIDTH'(1);

	typedef struct packed {
		logic signed [COMP_WIDTH-1:0] first_x;
		logic signed [COMP_WIDTH-1:0] first_y;
		logic signed [COMP_WIDTH-1:0] first_z;
		logic signed [COMP_WIDTH-1:0] first_w;
		logic signed [COMP_WIDTH-1:0] second_x;
		logic signed [COMP_WIDTH-1:0] second_y;
		logic signed [COMP_WIDTH-1:0] second_z;
		logic signed [COMP_WIDTH-1:0] second_w;
		logic [BLEND_WIDTH-1:0]       blend;
	} req_beat_t;

	typedef struct packed {
		logic signed [COMP_WIDTH-1:0] out_x;
		logic signed [COMP_WIDTH-1:0] out_y;
		logic signed [COMP_WIDTH-1:0] out_z;
		logic signed [COMP_WIDTH-1:0] out_w;
		logic                         degenerate;
	} rsp_beat_t;

endpackage

`default_nettype wire

// ===== sv/quaternion_nlerp.sv =====
// Normalized linear interpolation of two Q2.14 quaternions. One beat is accepted every
// clock cycle while the pipeline is not frozen. Four stages blend, square and sum,
// then a normalizer chain resolves one quotient bit per stage for each component,
// followed by the output register. The whole pipeline freezes while an output beat
// is held by rsp_stall. cfg_wr_data sets min_length (reset 1).
// uses qnlerp_pkg and qnlerp_norm
`default_nettype none

module quaternion_nlerp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [qnlerp_pkg::CFG_WIDTH-1:0]     cfg_wr_data,
	input  wire logic                                 req_valid,
	output logic                                      req_stall,
	input  wire qnlerp_pkg::req_beat_t                req_beat,
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_stall,
	output qnlerp_pkg::rsp_beat_t                     rsp_beat
);

	localparam int W   = qnlerp_pkg::COMP_WIDTH;
	localparam int BW  = qnlerp_pkg::BLEND_WIDTH;
	localparam int PW  = qnlerp_pkg::PROD_WIDTH;
	localparam int SQW = qnlerp_pkg::SQ_WIDTH;
	localparam int SW  = qnlerp_pkg::SUM_WIDTH;
	localparam int NL  = qnlerp_pkg::NORM_LAT;
	localparam int CW  = qnlerp_pkg::CFG_WIDTH;

	logic [CW-1:0] min_length_q;
	logic          en;

	assign en        = !rsp_valid || !rsp_stall;
	assign req_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= qnlerp_pkg::MIN_LENGTH_RST;
		end else if (cfg_wr_en) begin
			min_length_q <= cfg_wr_data;
		end
	end

	// stage 1: weighted products
	logic signed [W-1:0] fa [0:3];
	logic signed [W-1:0] sa [0:3];
	logic [BW:0]         a_sat;
	logic [BW:0]         a_inv;

	assign fa[0] = req_beat.first_x;
	assign fa[1] = req_beat.first_y;
	assign fa[2] = req_beat.first_z;
	assign fa[3] = req_beat.first_w;
	assign sa[0] = req_beat.second_x;
	assign sa[1] = req_beat.second_y;
	assign sa[2] = req_beat.second_z;
	assign sa[3] = req_beat.second_w;

	assign a_sat = ({1'b0, req_beat.blend} > qnlerp_pkg::BLEND_ONE) ?
		qnlerp_pkg::BLEND_ONE : {1'b0, req_beat.blend};
	assign a_inv = qnlerp_pkg::BLEND_ONE - a_sat;

	logic signed [PW-1:0] pf_s1 [0:3];
	logic signed [PW-1:0] ps_s1 [0:3];
	logic signed [W-1:0]  c_s2  [0:3];
	logic [SQW-1:0]       sq_s3 [0:3];
	logic signed [W-1:0]  c_s3  [0:3];
	logic [SQW-1:0]       sq_s4 [0:3];
	logic signed [W-1:0]  c_s4  [0:3];
	logic [SW-1:0]        sum_s4;
	logic                 v_s1, v_s2, v_s3, v_s4;

	for (genvar i = 0; i < 4; i++) begin : g_comp
		logic signed [PW:0]  m;
		logic [W-1:0]        mag;

		// round to nearest, ties toward +inf
		assign m = {pf_s1[i][PW-1], pf_s1[i]} + {ps_s1[i][PW-1], ps_s1[i]}
			+ (PW + 1)'(1 << (BW - 2));
		assign mag = c_s2[i][W-1] ? W'(-c_s2[i]) : W'(c_s2[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				pf_s1[i] <= fa[i] * $signed({1'b0, a_inv});
				ps_s1[i] <= sa[i] * $signed({1'b0, a_sat});
				c_s2[i]  <= m[BW-1 +: W];
				sq_s3[i] <= mag * mag;
				c_s3[i]  <= c_s2[i];
				sq_s4[i] <= sq_s3[i];
				c_s4[i]  <= c_s3[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]) + SW'(sq_s3[3]);
		end
	end

	logic [2*CW-1:0] thr;
	logic            deg;

	assign thr = min_length_q * min_length_q;
	assign deg = (sum_s4 == '0) || (sum_s4 < SW'(thr));

	logic signed [W-1:0] res [0:3];

	for (genvar i = 0; i < 4; i++) begin : g_norm
		qnlerp_norm u_norm (
			.clk    (clk),
			.en     (en),
			.comp   (c_s4[i]),
			.sq     (sq_s4[i]),
			.sum    (sum_s4),
			.result (res[i])
		);
	end

	logic v_n   [0:NL-1];
	logic deg_n [0:NL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k < NL; k++) begin
				v_n[k] <= 1'b0;
			end
			rsp_valid <= 1'b0;
		end else if (en) begin
			v_s1   <= req_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_n[0] <= v_s4;
			for (int k = 1; k < NL; k++) begin
				v_n[k] <= v_n[k-1];
			end
			rsp_valid <= v_n[NL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_n[0] <= deg;
			for (int k = 1; k < NL; k++) begin
				deg_n[k] <= deg_n[k-1];
			end
			if (deg_n[NL-1]) begin
				rsp_beat.out_x <= '0;
				rsp_beat.out_y <= '0;
				rsp_beat.out_z <= '0;
				rsp_beat.out_w <= W'(1) << qnlerp_pkg::FRAC_BITS;
			end else begin
				rsp_beat.out_x <= res[0];
				rsp_beat.out_y <= res[1];
				rsp_beat.out_z <= res[2];
				rsp_beat.out_w <= res[3];
			end
			rsp_beat.degenerate <= deg_n[NL-1];
		end
	end

endmodule

`default_nettype wire

// ===== sv/qnlerp_norm.sv =====
// one component's normalizer: round(|c| * 2^F / sqrt(S)) one quotient bit per stage
// uses qnlerp_pkg; stages advance together on en
`default_nettype none

module qnlerp_norm (
	input  wire logic                                    clk,
	input  wire logic                                    en,
	input  wire logic signed [qnlerp_pkg::COMP_WIDTH-1:0] comp,
	input  wire logic [qnlerp_pkg::SQ_WIDTH-1:0]          sq,
	input  wire logic [qnlerp_pkg::SUM_WIDTH-1:0]         sum,
	output logic signed [qnlerp_pkg::COMP_WIDTH-1:0]      result
);

	localparam int W  = qnlerp_pkg::COMP_WIDTH;
	localparam int F  = qnlerp_pkg::FRAC_BITS;
	localparam int AW = qnlerp_pkg::ACC_WIDTH;
	localparam int QW = qnlerp_pkg::QUO_WIDTH;

	// d = 4*mag^2*2^2F - (2q-1)^2*S,  p = (2q-1)*S
	logic signed [AW-1:0] d_s [0:QW];
	logic signed [AW-1:0] p_s [0:QW];
	logic signed [AW-1:0] s_s [0:QW];
	logic [QW-1:0]        q_s [0:QW];
	logic                 neg_s [0:QW];

	logic signed [AW-1:0] sum_ext;
	logic signed [AW-1:0] sq_ext;

	assign sum_ext = $signed({{(AW - qnlerp_pkg::SUM_WIDTH){1'b0}}, sum});
	assign sq_ext  = $signed({{(AW - qnlerp_pkg::SQ_WIDTH){1'b0}}, sq});

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0]   <= (sq_ext <<< (2 * F + 2)) - sum_ext;
			p_s[0]   <= -sum_ext;
			s_s[0]   <= sum_ext;
			q_s[0]   <= '0;
			neg_s[0] <= comp[W-1];
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_bit
		localparam int B = F - (k - 1);
		logic signed [AW-1:0] trial;

		assign trial = d_s[k-1] - (p_s[k-1] <<< (B + 2)) - (s_s[k-1] <<< (2 * B + 2));

		always_ff @(posedge clk) begin
			if (en) begin
				s_s[k]   <= s_s[k-1];
				neg_s[k] <= neg_s[k-1];
				if (!trial[AW-1]) begin
					d_s[k] <= trial;
					p_s[k] <= p_s[k-1] + (s_s[k-1] <<< (B + 1));
					q_s[k] <= q_s[k-1] | (QW'(1) << B);
				end else begin
					d_s[k] <= d_s[k-1];
					p_s[k] <= p_s[k-1];
					q_s[k] <= q_s[k-1];
				end
			end
		end
	end

	logic signed [W-1:0] mag;
	assign mag    = $signed({{(W - QW){1'b0}}, q_s[QW]});
	assign result = neg_s[QW] ? -mag : mag;

endmodule

`default_nettype wire

// ===== tb/quaternion_nlerp_test.sv =====
// self-checking bench for quaternion_nlerp: random and directed quaternion pairs,
// random idling on both sides, results predicted in place and compared beat by beat
// depends on qnlerp_pkg and quaternion_nlerp
`default_nettype none

module quaternion_nlerp_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [qnlerp_pkg::CFG_WIDTH-1:0] cfg_wr_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	qnlerp_pkg::req_beat_t req_beat = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	qnlerp_pkg::rsp_beat_t rsp_beat;

	quaternion_nlerp dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_beat(req_beat),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_beat(rsp_beat)
	);

	qnlerp_pkg::req_beat_t pending_pairs[$];
	qnlerp_pkg::rsp_beat_t expected_rot[$];
	logic [qnlerp_pkg::CFG_WIDTH-1:0] min_length = qnlerp_pkg::MIN_LENGTH_RST;
	int idle_mode = 0;
	int mismatches = 0;
	int send_gap = 0;
	int stall_left = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int draw_idle();
		case (idle_mode)
			0: return 0;
			1: return $urandom_range(0, 18);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
		endcase
	endfunction

	// blend one component, round half up
	function automatic longint mix(logic signed [qnlerp_pkg::COMP_WIDTH-1:0] x,
			logic signed [qnlerp_pkg::COMP_WIDTH-1:0] y, longint a);
		longint m;
		m = longint'(x) * (32768 - a) + longint'(y) * a + 16384;
		return m >>> 15;
	endfunction

	// round(|c| * 2^F / sqrt(s)), ties away from zero, by bitwise search
	function automatic logic signed [qnlerp_pkg::COMP_WIDTH-1:0] scale(longint c,
			logic [127:0] s);
		logic [127:0] mag, rhs, lhs, k;
		logic [63:0] q, t;
		mag = (c < 0) ? 128'(-c) : 128'(c);
		rhs = (mag * mag) << (2 * qnlerp_pkg::FRAC_BITS + 2);
		q = 0;
		for (int b = qnlerp_pkg::FRAC_BITS; b >= 0; b--) begin
			t = q | (64'd1 << b);
			k = 128'(2 * t - 1);
			lhs = k * k * s;
			if (lhs <= rhs)
				q = t;
		end
		return (c < 0) ? -qnlerp_pkg::COMP_WIDTH'(q) : qnlerp_pkg::COMP_WIDTH'(q);
	endfunction

	function automatic qnlerp_pkg::rsp_beat_t nlerp_of(qnlerp_pkg::req_beat_t p);
		qnlerp_pkg::rsp_beat_t r;
		longint a;
		longint c[4];
		logic [127:0] s;
		a = p.blend;
		if (a > 32768)
			a = 32768;
		c[0] = mix(p.first_x, p.second_x, a);
		c[1] = mix(p.first_y, p.second_y, a);
		c[2] = mix(p.first_z, p.second_z, a);
		c[3] = mix(p.first_w, p.second_w, a);
		s = 0;
		for (int i = 0; i < 4; i++)
			s += 128'(c[i] * c[i]);
		if (s == 0 || s < 128'(min_length) * 128'(min_length)) begin
			r = '0;
			r.out_w = qnlerp_pkg::COMP_WIDTH'(1) << qnlerp_pkg::FRAC_BITS;
			r.degenerate = 1'b1;
		end else begin
			r.out_x = scale(c[0], s);
			r.out_y = scale(c[1], s);
			r.out_z = scale(c[2], s);
			r.out_w = scale(c[3], s);
			r.degenerate = 1'b0;
		end
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (req_valid && !req_stall)
				expected_rot.push_back(nlerp_of(req_beat));
			if (!req_valid || !req_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					req_beat <= pending_pairs.pop_front();
					req_valid <= 1'b1;
					send_gap <= draw_idle();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else if (rsp_valid && !rsp_stall) begin
			qnlerp_pkg::rsp_beat_t e;
			int n;
			n = draw_idle();
			if (expected_rot.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result beat %p", rsp_beat);
				mismatches++;
			end else begin
				e = expected_rot.pop_front();
				if (e.out_x !== rsp_beat.out_x || e.out_y !== rsp_beat.out_y ||
						e.out_z !== rsp_beat.out_z || e.out_w !== rsp_beat.out_w ||
						e.degenerate !== rsp_beat.degenerate) begin
					if (mismatches < 10)
						$display("mismatch: expected %p got %p", e, rsp_beat);
					mismatches++;
				end
			end
			stall_left <= n;
			rsp_stall <= (n != 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= (stall_left > 1);
		end
	end

	function automatic logic [15:0] rand_comp(int kind);
		case (kind)
			0: return 16'($urandom_range(0, 64)) - 16'd32;
			1: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic qnlerp_pkg::req_beat_t rand_pair();
		qnlerp_pkg::req_beat_t p;
		int kind;
		int sel;
		sel = $urandom_range(0, 9);
		kind = (sel < 2) ? 0 : (sel == 2) ? 1 : 2;
		p.first_x = rand_comp(kind);
		p.first_y = rand_comp(kind);
		p.first_z = rand_comp(kind);
		p.first_w = rand_comp(kind);
		p.second_x = rand_comp(kind);
		p.second_y = rand_comp(kind);
		p.second_z = rand_comp(kind);
		p.second_w = rand_comp(kind);
		p.blend = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
		// opposite pair at midpoint cancels to zero length
		if (sel == 9) begin
			p.second_x = -p.first_x;
			p.second_y = -p.first_y;
			p.second_z = -p.first_z;
			p.second_w = -p.first_w;
			p.blend = 16'd16384;
		end
		return p;
	endfunction

	task automatic settle();
		while (pending_pairs.size() > 0 || req_valid || expected_rot.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_min_length(logic [qnlerp_pkg::CFG_WIDTH-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		min_length = v;
	endtask

	initial begin
		logic [qnlerp_pkg::CFG_WIDTH-1:0] levels[6];
		levels = '{16'd1, 16'd0, 16'hffff, 16'd16384, 16'd300, 16'd0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero length, extremes, blend ends and overrange, tiny lengths
		pending_pairs.push_back('0);
		pending_pairs.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd0});
		pending_pairs.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd32768});
		pending_pairs.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff});
		pending_pairs.push_back('{16'h8000, 16'h0, 16'h0, 16'h0,
			16'h0, 16'h7fff, 16'h0, 16'h0, 16'h8001});
		pending_pairs.push_back('{16'h0, 16'h0, 16'h0, 16'h4000,
			16'h4000, 16'h0, 16'h0, 16'h0, 16'd16384});
		pending_pairs.push_back('{16'h1234, 16'h0, 16'h0, 16'h0,
			16'hedcc, 16'h0, 16'h0, 16'h0, 16'd16384});
		pending_pairs.push_back('{16'h0, 16'h0, 16'h0, 16'h1,
			16'h0, 16'h0, 16'h0, 16'h1, 16'd100});
		pending_pairs.push_back('{16'hffff, 16'h0, 16'h0, 16'h0,
			16'h0, 16'h0, 16'h0, 16'h0, 16'd0});
		pending_pairs.push_back('{16'h1, 16'h1, 16'h1, 16'h1,
			16'h1, 16'h1, 16'h1, 16'h1, 16'd32767});
		pending_pairs.push_back('{16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0,
			16'haaaa, 16'h5555, 16'hf0f0, 16'h0f0f, 16'd1});
		pending_pairs.push_back('{16'h4000, 16'h0, 16'h0, 16'h0,
			16'h0, 16'h0, 16'h0, 16'h0, 16'd32767});
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			set_min_length(ph == 4 ? 16'($urandom()) : levels[ph]);
			idle_mode = ph % 3;
			for (int i = 0; i < 320; i++)
				pending_pairs.push_back(rand_pair());
			settle();
		end

		if (mismatches == 0 && expected_rot.size() == 0)
			$display("quaternion_nlerp_test OK");
		else
			$display("quaternion_nlerp_test NOT OK");
		$finish;
	end

	initial begin
		#5ms;
		$display("quaternion_nlerp_test NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
